[design/dahdsr_envelope_bank_core_defines.svh]
// assertion macros used by the envelope bank controller
`ifndef DAHDSR_ENVELOPE_BANK_CORE_DEFINES_SVH
`define DAHDSR_ENVELOPE_BANK_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DAHDSR_ASSERT_NOW(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("dahdsr: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define DAHDSR_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("dahdsr: next-cycle check failed");

`endif

[design/dahdsr_pkg.sv]
// shared types, codes and constants of the envelope bank
package dahdsr_pkg;

	// level format
	localparam int LEVEL_FRAC_BITS = 24;
	localparam int LW = LEVEL_FRAC_BITS + 1;
	localparam int UNITY_INT = 1 << LEVEL_FRAC_BITS;
	localparam logic [LW-1:0] UNITY = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
	// exponential release ends at or below 1e-5 of full level
	localparam logic [LW-1:0] REL_FLOOR = LW'(UNITY_INT / 100000);

	// parameter defaults
	localparam int VOICES_DEF = 256;
	localparam int FRAME_BITS_DEF = 20;

	// commands
	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic [1:0] CMD_KILL    = 2'd3;

	// envelope stages
	typedef logic [2:0] stage_t;
	localparam stage_t ST_IDLE    = 3'd0;
	localparam stage_t ST_DELAY   = 3'd1;
	localparam stage_t ST_ATTACK  = 3'd2;
	localparam stage_t ST_HOLD    = 3'd3;
	localparam stage_t ST_DECAY   = 3'd4;
	localparam stage_t ST_SUSTAIN = 3'd5;
	localparam stage_t ST_RELEASE = 3'd6;

	// arithmetic unit operations
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_ROOT = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  voice;
		logic [19:0] delay_frames;
		logic [19:0] attack_frames;
		logic [19:0] hold_frames;
		logic [19:0] decay_frames;
		logic [19:0] release_frames;
		logic [24:0] sustain_level;
		logic        exponential;
	} in_t;

	typedef struct packed {
		logic [7:0]  voice_out;
		logic [24:0] level;
		logic [2:0]  stage;
		logic        retired;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load_in;
		logic latch_rec;
		logic start_op;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic need_op;
		logic busy;
	} ctrl_st_t;

endpackage

[design/dahdsr_ram.sv]
// generic simple dual-port ram with registered read
module dahdsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/dahdsr_arith.sv]
// shared iterative unit: restoring divider and bisection root of a fixed-point pow
module dahdsr_arith #(
	parameter int FRAME_BITS = dahdsr_pkg::FRAME_BITS_DEF,
	localparam int DW = ((FRAME_BITS > dahdsr_pkg::LW) ? FRAME_BITS : dahdsr_pkg::LW) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    op,
	input  logic [DW-1:0]                 opa,
	input  logic [FRAME_BITS-1:0]         opb,
	output logic                          busy,
	output logic [dahdsr_pkg::LW-1:0]     result
);
	import dahdsr_pkg::*;

	localparam int FB = FRAME_BITS;
	localparam int CW = $clog2(DW + 1);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_DIV  = 2'd1;
	localparam logic [1:0] P_ITER = 2'd2;
	localparam logic [1:0] P_POW  = 2'd3;

	logic [1:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] num_q;
	logic [DW-1:0] quo_q;
	logic [FB-1:0] rem_q;
	logic [FB-1:0] den_q;
	logic [LW-1:0] lo_q, hi_q, mid_q, x_q, acc_q, f_q;
	logic [FB-1:0] n_q, nn_q;
	logic [LW-1:0] res_q;

	logic [FB:0]     trial, trial_sub;
	logic            ge;
	logic [FB-1:0]   rem_n;
	logic [DW-1:0]   quo_n;
	logic [LW-1:0]   span, mid;
	logic [2*LW-1:0] prod_af, prod_ff;
	logic [LW-1:0]   x_in;
	logic [FB-1:0]   n_in;

	// one quotient bit per cycle
	assign trial     = {rem_q, num_q[DW-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = (trial >= {1'b0, den_q});
	assign rem_n     = ge ? trial_sub[FB-1:0] : trial[FB-1:0];
	assign quo_n     = {quo_q[DW-2:0], ge};

	// bisection midpoint and the two truncating products of one pow step
	assign span    = hi_q - lo_q;
	assign mid     = lo_q + (span >> 1);
	assign prod_af = acc_q * f_q;
	assign prod_ff = f_q * f_q;

	// operand clamps for the root search
	assign x_in = (opa > DW'(UNITY)) ? UNITY :
		((opa == '0) ? LW'(1) : opa[LW-1:0]);
	assign n_in = (opb == '0) ? FB'(1) : opb;

	// control state of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
		end else begin
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= (op == OP_DIV) ? P_DIV : P_ITER;
					end
				end
				P_DIV: begin
					if (cnt_q == CW'(1)) begin
						phase_q <= P_IDLE;
					end
				end
				P_ITER: begin
					phase_q <= (span > LW'(1)) ? P_POW : P_IDLE;
				end
				P_POW: begin
					if (nn_q == '0) begin
						phase_q <= P_ITER;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (start) begin
					num_q <= opa;
					den_q <= opb;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(DW);
					lo_q  <= '0;
					hi_q  <= UNITY;
					x_q   <= x_in;
					n_q   <= n_in;
				end
			end
			P_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				num_q <= num_q << 1;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					res_q <= quo_n[LW-1:0];
				end
			end
			P_ITER: begin
				if (span > LW'(1)) begin
					mid_q <= mid;
					acc_q <= UNITY;
					f_q   <= mid;
					nn_q  <= n_q;
				end else begin
					res_q <= hi_q;
				end
			end
			P_POW: begin
				if (nn_q != '0) begin
					if (nn_q[0]) begin
						acc_q <= prod_af[LEVEL_FRAC_BITS +: LW];
					end
					f_q  <= prod_ff[LEVEL_FRAC_BITS +: LW];
					nn_q <= nn_q >> 1;
				end else if (acc_q >= x_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			default: ;
		endcase
	end

	assign busy   = (phase_q != P_IDLE);
	assign result = res_q;

endmodule

[design/dahdsr_dp.sv]
// datapath: voice record memory, next-record logic, arithmetic unit and result register
module dahdsr_dp #(
	parameter int VOICES = dahdsr_pkg::VOICES_DEF,
	parameter int FRAME_BITS = dahdsr_pkg::FRAME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dahdsr_pkg::ctrl_cmd_t ctl,
	output dahdsr_pkg::ctrl_st_t  st,
	input  dahdsr_pkg::in_t       in_data,
	output dahdsr_pkg::out_t      out_data
);
	import dahdsr_pkg::*;

	localparam int FB = FRAME_BITS;
	localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int DW = ((FB > LW) ? FB : LW) + 1;

	typedef struct packed {
		stage_t        stage;
		logic [LW-1:0] level;
		logic [LW-1:0] step;
		logic [FB-1:0] rem;
		logic [FB-1:0] atk;
		logic [FB-1:0] hld;
		logic [FB-1:0] dcy;
		logic [FB-1:0] rel;
		logic [LW-1:0] sus;
		logic          curve;
	} rec_t;

	localparam int RW = $bits(rec_t);

	logic [AW-1:0]   clr_cnt_q;
	in_t             inp_q;
	rec_t            rec_q;
	logic [LW-1:0]   mul_q;
	out_t            out_q;
	logic [RW-1:0]   rdata;
	rec_t            rd;
	logic [2*LW-1:0] prod_lv;
	logic            in_range;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [RW-1:0]   ram_wdata;
	logic            op_busy;
	logic [LW-1:0]   op_res;

	logic [FB-1:0] i_dly, i_atk, i_hld, i_dcy, i_rel;
	logic [LW-1:0] i_sus;

	rec_t          nr;
	logic [1:0]    op;
	logic [DW-1:0] opa;
	logic [FB-1:0] opb;
	logic [LW-1:0] lvl_o;
	logic          ret;

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clear) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// latch the transaction
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			inp_q <= in_data;
		end
	end

	// voice record memory
	assign ram_we    = ctl.clear | (ctl.commit & in_range);
	assign ram_waddr = ctl.clear ? clr_cnt_q : AW'(inp_q.voice);
	assign ram_wdata = ctl.clear ? '0 : RW'(nr);

	dahdsr_ram #(
		.WIDTH(RW),
		.DEPTH(VOICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.load_in),
		.raddr (AW'(in_data.voice)),
		.rdata (rdata)
	);

	// record copy and the exponential shrink product
	assign rd      = rec_t'(rdata);
	assign prod_lv = rd.level * rd.step;

	always_ff @(posedge clk) begin
		if (ctl.latch_rec) begin
			rec_q <= rd;
			mul_q <= prod_lv[LEVEL_FRAC_BITS +: LW];
		end
	end

	// input fields in storage format
	assign in_range = (int'(inp_q.voice) < VOICES);
	assign i_dly = FB'(inp_q.delay_frames);
	assign i_atk = FB'(inp_q.attack_frames);
	assign i_hld = FB'(inp_q.hold_frames);
	assign i_dcy = FB'(inp_q.decay_frames);
	assign i_rel = FB'(inp_q.release_frames);
	assign i_sus = (inp_q.sustain_level > UNITY) ? UNITY : inp_q.sustain_level;

	// next record, operation request and result
	always_comb begin
		logic [FB-1:0] rem_dec;
		logic [LW-1:0] shr;
		logic [LW:0]   sum_w;
		logic [LW-1:0] atk_sum;
		logic          go_atk, go_hld, go_dcy;

		nr     = rec_q;
		op     = OP_NONE;
		opa    = '0;
		opb    = '0;
		ret    = 1'b0;
		go_atk = 1'b0;
		go_hld = 1'b0;
		go_dcy = 1'b0;
		lvl_o  = '0;

		rem_dec = (rec_q.rem != '0) ? rec_q.rem - FB'(1) : '0;
		shr = rec_q.curve ? mul_q :
			((rec_q.level > rec_q.step) ? rec_q.level - rec_q.step : '0);
		sum_w = {1'b0, rec_q.level} + {1'b0, rec_q.step};
		atk_sum = (sum_w > {1'b0, UNITY}) ? UNITY : sum_w[LW-1:0];

		if (in_range) begin
			unique case (inp_q.command)
				CMD_START: begin
					nr.atk   = i_atk;
					nr.hld   = i_hld;
					nr.dcy   = i_dcy;
					nr.rel   = i_rel;
					nr.sus   = i_sus;
					nr.curve = inp_q.exponential;
					nr.level = '0;
					nr.step  = '0;
					nr.rem   = i_dly;
					if (i_dly != '0) begin
						nr.stage = ST_DELAY;
					end else begin
						go_atk = 1'b1;
					end
				end
				CMD_RELEASE: begin
					if (rec_q.stage != ST_IDLE && rec_q.stage != ST_RELEASE) begin
						if (rec_q.rel == '0 || rec_q.level == '0) begin
							nr.level = '0;
							nr.step  = '0;
							nr.stage = ST_IDLE;
							ret      = 1'b1;
						end else begin
							nr.step  = op_res;
							nr.rem   = rec_q.rel;
							nr.stage = ST_RELEASE;
							opb      = rec_q.rel;
							if (rec_q.curve) begin
								op  = OP_ROOT;
								opa = DW'(REL_FLOOR);
							end else begin
								op  = OP_DIV;
								opa = DW'(rec_q.level) + DW'(rec_q.rel) - DW'(1);
							end
						end
					end
				end
				CMD_TICK: begin
					case (rec_q.stage)
						ST_DELAY: begin
							nr.rem = rem_dec;
							go_atk = (rem_dec == '0);
						end
						ST_ATTACK: begin
							nr.level = atk_sum;
							nr.rem   = rem_dec;
							go_hld   = (rem_dec == '0);
						end
						ST_HOLD: begin
							nr.rem = rem_dec;
							go_dcy = (rem_dec == '0);
						end
						ST_DECAY: begin
							nr.level = shr;
							nr.rem   = rem_dec;
							if (rem_dec == '0) begin
								nr.level = rec_q.sus;
								nr.step  = '0;
								nr.stage = ST_SUSTAIN;
							end
						end
						ST_RELEASE: begin
							nr.level = shr;
							nr.rem   = rem_dec;
							if (rem_dec == '0 || shr <= (rec_q.curve ? REL_FLOOR : '0)) begin
								nr.level = '0;
								nr.step  = '0;
								nr.stage = ST_IDLE;
								ret      = 1'b1;
							end
						end
						default: ;
					endcase
				end
				CMD_KILL: begin
					if (rec_q.stage != ST_IDLE) begin
						nr.level = '0;
						nr.step  = '0;
						nr.stage = ST_IDLE;
						ret      = 1'b1;
					end
				end
				default: ;
			endcase

			// enter attack, or fall through when its length is zero
			if (go_atk) begin
				if (nr.atk != '0) begin
					nr.level = '0;
					nr.step  = op_res;
					nr.rem   = nr.atk;
					nr.stage = ST_ATTACK;
					op       = OP_DIV;
					opa      = DW'(UNITY);
					opb      = nr.atk;
				end else begin
					go_hld = 1'b1;
				end
			end

			// enter hold at full level
			if (go_hld) begin
				nr.level = UNITY;
				nr.step  = '0;
				if (nr.hld != '0) begin
					nr.stage = ST_HOLD;
					nr.rem   = nr.hld;
				end else begin
					go_dcy = 1'b1;
				end
			end

			// enter decay, or go straight to sustain
			if (go_dcy) begin
				if (nr.dcy != '0 && nr.sus < UNITY) begin
					nr.stage = ST_DECAY;
					nr.rem   = nr.dcy;
					nr.step  = op_res;
					opb      = nr.dcy;
					if (nr.curve) begin
						op  = OP_ROOT;
						opa = DW'(nr.sus);
					end else begin
						op  = OP_DIV;
						opa = DW'(UNITY - nr.sus);
					end
				end else begin
					nr.level = nr.sus;
					nr.step  = '0;
					nr.rem   = '0;
					nr.stage = ST_SUSTAIN;
				end
			end

			// tick shows the level before its advance
			if (inp_q.command == CMD_TICK) begin
				lvl_o = (rec_q.stage != ST_IDLE) ? rec_q.level : '0;
			end else begin
				lvl_o = (nr.stage != ST_IDLE) ? nr.level : '0;
			end
		end
	end

	// shared divider and root unit
	dahdsr_arith #(
		.FRAME_BITS(FB)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start_op),
		.op     (op),
		.opa    (opa),
		.opb    (opb),
		.busy   (op_busy),
		.result (op_res)
	);

	// result register
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_q.voice_out <= inp_q.voice;
			out_q.level     <= in_range ? lvl_o : '0;
			out_q.stage     <= in_range ? nr.stage : ST_IDLE;
			out_q.retired   <= in_range & ret;
		end
	end

	assign out_data    = out_q;
	assign st.clr_last = (clr_cnt_q == AW'(VOICES - 1));
	assign st.need_op  = (op != OP_NONE);
	assign st.busy     = op_busy;

endmodule

[design/dahdsr_ctrl.sv]
// controller: sequences clearing, read, plan, arithmetic wait and write-back
`include "dahdsr_envelope_bank_core_defines.svh"

module dahdsr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	output dahdsr_pkg::ctrl_cmd_t ctl,
	input  dahdsr_pkg::ctrl_st_t  st
);
	import dahdsr_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_PLAN = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			S_CLR: begin
				ctl.clear = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				ctl.latch_rec = 1'b1;
				state_d       = S_PLAN;
			end
			S_PLAN: begin
				if (st.need_op) begin
					ctl.start_op = 1'b1;
					state_d      = S_WAIT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WAIT: begin
				if (!st.busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || res_ready) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// result slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;

	// checks
	`DAHDSR_ASSERT_NEXT(a_start_busy, clk, arst_n, ctl.start_op, st.busy)
	`DAHDSR_ASSERT_NOW(a_commit_idle_unit, clk, arst_n, ctl.commit, !st.busy)
	`DAHDSR_ASSERT_NOW(a_commit_slot_free, clk, arst_n, ctl.commit, (!out_valid_q || res_ready))

endmodule

[design/dahdsr_envelope_bank_core.sv]
// Bank of per-voice delay-attack-hold-decay-sustain-release envelopes, one result per
// command transaction. After reset the voice record memory is cleared voice by voice,
// during which no command is taken. A start, tick, kill or release that needs no arithmetic
// passes through accept, record read, plan and write-back, the read-modify-write of the
// single voice record memory; write-back waits while the output register is still full.
// An entry into attack, linear decay or linear release also runs the bit-serial divider.
// An entry into exponential decay or release runs the bisection pow search of 24 rounds,
// each raising the midpoint to the power of the frame count. A finished result is held
// in an output register and the next command is taken while it waits.
module dahdsr_envelope_bank_core #(
	parameter int VOICES = dahdsr_pkg::VOICES_DEF,
	parameter int FRAME_BITS = dahdsr_pkg::FRAME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  dahdsr_pkg::in_t  cmd_data,
	output logic             res_valid,
	input  logic             res_ready,
	output dahdsr_pkg::out_t res_data
);
	import dahdsr_pkg::*;

	ctrl_cmd_t ctl;
	ctrl_st_t  st;

	// controller
	dahdsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctl       (ctl),
		.st        (st)
	);

	// datapath
	dahdsr_dp #(
		.VOICES     (VOICES),
		.FRAME_BITS (FRAME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.st       (st),
		.in_data  (cmd_data),
		.out_data (res_data)
	);

endmodule
